>>> rtl/utcd_pkg.sv
// shared constants, reciprocal multipliers and types of the unix time to date pipeline
// no dependencies; imported by utcd_pipe_ctrl and unix_time_to_calendar_date_top

package utcd_pkg;

   localparam int NUM_STAGES = 6;

   // field widths
   localparam int SECS_W    = 31;
   localparam int DAYS_W    = 15;
   localparam int SOD_W     = 17;
   localparam int SOH_W     = 12;
   localparam int JD_W      = 22;
   localparam int NUM_W     = 26;
   localparam int CY_W      = 13;
   localparam int DOY_W     = 10;
   localparam int MI_W      = 4;
   localparam int SEC_W     = 6;
   localparam int MIN_W     = 6;
   localparam int HOUR_W    = 5;
   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 11;

   localparam logic [SECS_W-1:0] SEC_PER_DAY  = 31'd86400;
   localparam logic [SOD_W-1:0]  SEC_PER_HOUR = 17'd3600;
   localparam logic [SOH_W-1:0]  SEC_PER_MIN  = 12'd60;

   // seconds / 86400 = (seconds >> 7) / 675
   localparam int          DAY_PRE   = 7;
   localparam int          DAY_K     = 34;
   localparam int          DAY_M_W   = 25;
   localparam logic [63:0] DAY_DIV   = 64'd675;
   localparam logic [63:0] DAY_M_RAW = ((64'd1 << DAY_K) + DAY_DIV - 64'd1) / DAY_DIV;
   localparam logic [DAY_M_W-1:0] DAY_M = DAY_M_RAW[DAY_M_W-1:0];

   // second of day / 3600 = (sod >> 4) / 225
   localparam int          HOUR_PRE   = 4;
   localparam int          HOUR_K     = 21;
   localparam int          HOUR_M_W   = 14;
   localparam logic [63:0] HOUR_DIV   = 64'd225;
   localparam logic [63:0] HOUR_M_RAW = ((64'd1 << HOUR_K) + HOUR_DIV - 64'd1) / HOUR_DIV;
   localparam logic [HOUR_M_W-1:0] HOUR_M = HOUR_M_RAW[HOUR_M_W-1:0];

   // second of hour / 60 = (soh >> 2) / 15
   localparam int          MIN_PRE   = 2;
   localparam int          MIN_K     = 14;
   localparam int          MIN_M_W   = 11;
   localparam logic [63:0] MIN_DIV   = 64'd15;
   localparam logic [63:0] MIN_M_RAW = ((64'd1 << MIN_K) + MIN_DIV - 64'd1) / MIN_DIV;
   localparam logic [MIN_M_W-1:0] MIN_M = MIN_M_RAW[MIN_M_W-1:0];

   // (20 * jd - 2442) / 7305
   localparam int          CY_K     = 39;
   localparam int          CY_M_W   = 27;
   localparam logic [63:0] CY_DIV   = 64'd7305;
   localparam logic [63:0] CY_M_RAW = ((64'd1 << CY_K) + CY_DIV - 64'd1) / CY_DIV;
   localparam logic [CY_M_W-1:0] CY_M = CY_M_RAW[CY_M_W-1:0];

   // (1000 * doy) / 30601
   localparam int          MI_K     = 25;
   localparam int          MI_M_W   = 21;
   localparam logic [63:0] MI_DIV   = 64'd30601;
   localparam logic [63:0] MI_M_RAW = ((64'd1000 << MI_K) + MI_DIV - 64'd1) / MI_DIV;
   localparam logic [MI_M_W-1:0] MI_M = MI_M_RAW[MI_M_W-1:0];

   // the leap adjustment a - a/4 is 12 for every day count in range
   localparam logic [JD_W-1:0]  JD_OFFSET    = 22'd2442125;
   localparam logic [NUM_W-1:0] JD_SCALE     = 26'd20;
   localparam logic [NUM_W-1:0] JD_BIAS      = 26'd2442;
   localparam logic [JD_W-1:0]  DAYS_PER_YR  = 22'd365;
   localparam logic [DOY_W-1:0] DAYS_PER_MI  = 10'd30;
   localparam logic [MI_W-1:0]  LAST_LATE_MI = 4'd13;
   localparam logic [MI_W-1:0]  FOLD_EARLY   = 4'd13;
   localparam logic [MI_W-1:0]  FOLD_LATE    = 4'd1;
   localparam logic [CY_W-1:0]  YEAR_BIAS_LATE  = 13'd4716;
   localparam logic [CY_W-1:0]  YEAR_BIAS_EARLY = 13'd4715;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // (601 * mi) / 1000 for a month index of 0 to 15
   function automatic logic [DOY_W-1:0] mi_frac_days(input logic [MI_W-1:0] mi);
      logic [DOY_W-1:0] r;
      case (mi)
         4'd0, 4'd1:   r = 10'd0;
         4'd2, 4'd3:   r = 10'd1;
         4'd4:         r = 10'd2;
         4'd5, 4'd6:   r = 10'd3;
         4'd7, 4'd8:   r = 10'd4;
         4'd9:         r = 10'd5;
         4'd10, 4'd11: r = 10'd6;
         4'd12, 4'd13: r = 10'd7;
         4'd14:        r = 10'd8;
         default:      r = 10'd9;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/utcd_pipe_ctrl.sv
// valid and load control of the six register stages, with bubble collapse
// depends on utcd_pkg

module utcd_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    rsp_stall,
   output utcd_pkg::pipe_ctrl_type ctrl
);
   import utcd_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;
   logic                  in_acc;
   logic                  out_acc;

   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
      valid_in = valid_ff;
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (ready[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall  = !ready[0];
   assign ctrl.load  = ready;
   assign ctrl.valid = valid_ff;
   assign in_acc     = req_valid && !req_stall;
   assign out_acc    = valid_ff[NUM_STAGES-1] && !rsp_stall;

   // items in flight change only by what enters and leaves
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones(valid_ff) ==
         $countones($past(valid_ff)) + int'($past(in_acc)) - int'($past(out_acc)))
      else $error("item count in pipeline broken");

   // input is held off only with every stage full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled with a free stage");

   // a stalled output keeps the stage behind it occupied
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      valid_ff[NUM_STAGES-1] && rsp_stall && valid_ff[NUM_STAGES-2]
         |=> valid_ff[NUM_STAGES-2] && valid_ff[NUM_STAGES-1])
      else $error("item dropped under stall");

endmodule

>>> rtl/unix_time_to_calendar_date_top.sv
// top level: unix seconds to calendar date and time of day, six register stages
// depends on utcd_pkg and utcd_pipe_ctrl
//
// usage:
//   req channel carries one signed 32-bit unix time per item (req_valid/req_stall).
//   values below one are taken as 1970-01-01 00:00:00.
//   rsp channel returns second, minute, hour, day, month and year, one item per
//   request, in order (rsp_valid/rsp_stall).
//   each item passes through the six register stages in order; one item per cycle
//   sustained while rsp_stall is low, set by the six register stages each holding one item.
//   every division is by a constant: reciprocal multiply, one multiplier per
//   path per stage, registered before the next product.
//   when rsp_stall is high the result holds and empty stages in front of it
//   still fill; req_stall rises only once all six stages hold an item.
//   synchronous reset empties the pipeline; no results are pending afterward.
//   the block keeps no state between items.

module unix_time_to_calendar_date_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [31:0]             req_unix_seconds,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [utcd_pkg::SEC_W-1:0]     rsp_second,
   output logic [utcd_pkg::MIN_W-1:0]     rsp_minute,
   output logic [utcd_pkg::HOUR_W-1:0]    rsp_hour,
   output logic [utcd_pkg::DAY_W-1:0]     rsp_day_of_month,
   output logic [utcd_pkg::MONTH_W-1:0]   rsp_month_number,
   output logic [utcd_pkg::YEAR_W-1:0]    rsp_year_number
);
   import utcd_pkg::*;

   pipe_ctrl_type ctrl;

   // stage 0 -> 1
   logic [SECS_W-1:0]                 secs;
   logic [SECS_W-DAY_PRE-1:0]         day_x;
   logic [SECS_W-DAY_PRE+DAY_M_W-1:0] day_prod;
   logic [SECS_W-1:0]                 s1_secs_ff;
   logic [DAYS_W-1:0]                 s1_days_ff, s1_days_in;

   // stage 1 -> 2
   logic [SECS_W-1:0] day_base, sod_full;
   logic [JD_W-1:0]   s2_jd_ff, s2_jd_in;
   logic [SOD_W-1:0]  s2_sod_ff, s2_sod_in;
   logic [NUM_W-1:0]  s2_num_ff, s2_num_in;

   // stage 2 -> 3
   logic [SOD_W-HOUR_PRE+HOUR_M_W-1:0] hour_prod;
   logic [NUM_W+CY_M_W-1:0]            cy_prod;
   logic [SOD_W-1:0]                   s3_sod_ff;
   logic [JD_W-1:0]                    s3_jd_ff;
   logic [HOUR_W-1:0]                  s3_hour_ff, s3_hour_in;
   logic [CY_W-1:0]                    s3_cy_ff, s3_cy_in;

   // stage 3 -> 4
   logic [SOD_W-1:0]  soh_full;
   logic [JD_W-1:0]   doy_full;
   logic [SOH_W-1:0]  s4_soh_ff, s4_soh_in;
   logic [DOY_W-1:0]  s4_doy_ff, s4_doy_in;
   logic [HOUR_W-1:0] s4_hour_ff;
   logic [CY_W-1:0]   s4_cy_ff;

   // stage 4 -> 5
   logic [SOH_W-MIN_PRE+MIN_M_W-1:0] min_prod;
   logic [DOY_W+MI_M_W-1:0]          mi_prod;
   logic [SOH_W-1:0]                 s5_soh_ff;
   logic [DOY_W-1:0]                 s5_doy_ff;
   logic [HOUR_W-1:0]                s5_hour_ff;
   logic [CY_W-1:0]                  s5_cy_ff;
   logic [MIN_W-1:0]                 s5_min_ff, s5_min_in;
   logic [MI_W-1:0]                  s5_mi_ff, s5_mi_in;

   // stage 5 -> output
   logic [SOH_W-1:0]   sec_full;
   logic [DOY_W-1:0]   dom_full;
   logic [CY_W-1:0]    year_full;
   logic [MI_W-1:0]    month_full;
   logic [SEC_W-1:0]   rsp_second_ff;
   logic [MIN_W-1:0]   rsp_minute_ff;
   logic [HOUR_W-1:0]  rsp_hour_ff;
   logic [DAY_W-1:0]   rsp_day_ff;
   logic [MONTH_W-1:0] rsp_month_ff;
   logic [YEAR_W-1:0]  rsp_year_ff;

   utcd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   // clamp and whole days
   always_comb begin
      secs       = req_unix_seconds[31] ? '0 : req_unix_seconds[SECS_W-1:0];
      day_x      = secs[SECS_W-1:DAY_PRE];
      day_prod   = $bits(day_prod)'(day_x) * $bits(day_prod)'(DAY_M);
      s1_days_in = day_prod[DAY_K +: DAYS_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_secs_ff <= secs;
         s1_days_ff <= s1_days_in;
      end
   end

   // second of day and scaled day number
   always_comb begin
      day_base  = SECS_W'(s1_days_ff) * SEC_PER_DAY;
      sod_full  = s1_secs_ff - day_base;
      s2_sod_in = sod_full[SOD_W-1:0];
      s2_jd_in  = JD_W'(s1_days_ff) + JD_OFFSET;
      s2_num_in = NUM_W'(s2_jd_in) * JD_SCALE - JD_BIAS;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_sod_ff <= s2_sod_in;
         s2_jd_ff  <= s2_jd_in;
         s2_num_ff <= s2_num_in;
      end
   end

   // hour and cycle year
   always_comb begin
      hour_prod  = $bits(hour_prod)'(s2_sod_ff[SOD_W-1:HOUR_PRE]) * $bits(hour_prod)'(HOUR_M);
      s3_hour_in = hour_prod[HOUR_K +: HOUR_W];
      cy_prod    = $bits(cy_prod)'(s2_num_ff) * $bits(cy_prod)'(CY_M);
      s3_cy_in   = cy_prod[CY_K +: CY_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_sod_ff  <= s2_sod_ff;
         s3_jd_ff   <= s2_jd_ff;
         s3_hour_ff <= s3_hour_in;
         s3_cy_ff   <= s3_cy_in;
      end
   end

   // second of hour and day of shifted year
   always_comb begin
      soh_full  = s3_sod_ff - SOD_W'(s3_hour_ff) * SEC_PER_HOUR;
      s4_soh_in = soh_full[SOH_W-1:0];
      doy_full  = s3_jd_ff - JD_W'(s3_cy_ff) * DAYS_PER_YR - JD_W'(s3_cy_ff[CY_W-1:2]);
      s4_doy_in = doy_full[DOY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_soh_ff  <= s4_soh_in;
         s4_doy_ff  <= s4_doy_in;
         s4_hour_ff <= s3_hour_ff;
         s4_cy_ff   <= s3_cy_ff;
      end
   end

   // minute and month index
   always_comb begin
      min_prod  = $bits(min_prod)'(s4_soh_ff[SOH_W-1:MIN_PRE]) * $bits(min_prod)'(MIN_M);
      s5_min_in = min_prod[MIN_K +: MIN_W];
      mi_prod   = $bits(mi_prod)'(s4_doy_ff) * $bits(mi_prod)'(MI_M);
      s5_mi_in  = mi_prod[MI_K +: MI_W];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s5_soh_ff  <= s4_soh_ff;
         s5_doy_ff  <= s4_doy_ff;
         s5_hour_ff <= s4_hour_ff;
         s5_cy_ff   <= s4_cy_ff;
         s5_min_ff  <= s5_min_in;
         s5_mi_ff   <= s5_mi_in;
      end
   end

   // second, day of month, and january/february folded into the next year
   always_comb begin
      sec_full = s5_soh_ff - SOH_W'(s5_min_ff) * SEC_PER_MIN;
      dom_full = s5_doy_ff - DOY_W'(s5_mi_ff) * DAYS_PER_MI - mi_frac_days(s5_mi_ff);
      if (s5_mi_ff <= LAST_LATE_MI) begin
         year_full  = s5_cy_ff - YEAR_BIAS_LATE;
         month_full = s5_mi_ff - FOLD_LATE;
      end else begin
         year_full  = s5_cy_ff - YEAR_BIAS_EARLY;
         month_full = s5_mi_ff - FOLD_EARLY;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         rsp_second_ff <= sec_full[SEC_W-1:0];
         rsp_minute_ff <= s5_min_ff;
         rsp_hour_ff   <= s5_hour_ff;
         rsp_day_ff    <= dom_full[DAY_W-1:0];
         rsp_month_ff  <= month_full;
         rsp_year_ff   <= year_full[YEAR_W-1:0];
      end
   end

   assign rsp_valid        = ctrl.valid[NUM_STAGES-1];
   assign rsp_second       = rsp_second_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_day_of_month = rsp_day_ff;
   assign rsp_month_number = rsp_month_ff;
   assign rsp_year_number  = rsp_year_ff;

endmodule
